// ----- rtl/core/clms_pkg.sv -----
// clms_pkg: shared types and constants of the character display marquee scroller.
// Used by every module under rtl/core except clms_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package clms_pkg;

    localparam int TEXT_DEPTH_DEF  = 256;
    localparam int NUM_SLOTS_DEF   = 2;
    localparam int NUM_COLUMNS_DEF = 11;

    localparam int CMD_W   = 3;
    localparam int COL_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SPACING_W = 5;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_LOAD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PAUSE_ALL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAUSE_ROW  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME_ROW = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STOP_ALL   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STOP_ROW   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd2;

    localparam logic [7:0]           PERIOD_RST  = 8'd12;
    localparam logic [7:0]           DELAY_RST   = 8'd50;
    localparam logic [SPACING_W-1:0] SPACING_RST = 5'd3;

    typedef enum logic [2:0] {
        K_LOAD,
        K_PAUSE,
        K_RESUME,
        K_STOP,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               all_rows;
        logic [COL_W-1:0]   column;
        logic               row;
        logic [CHAR_W-1:0]  char_code;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [7:0]           period_ticks;
        logic [7:0]           delay_ticks;
        logic [SPACING_W-1:0] spacing_blanks;
    } t_cfg;

endpackage
`default_nettype wire

// ----- rtl/core/char_lcd_marquee_scroller_unit.sv -----
// char_lcd_marquee_scroller_unit: top level of the marquee scroller; holds the settings
// registers and joins clms_front (accept, classify, queue) to clms_back (execute, emit).
// Depends on clms_pkg, clms_front, clms_back, clms_ram.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------------
//   in      | i_in_valid / o_in_ready    | i_cmd, i_column, i_row, i_char_code, i_last
//   out     | o_out_valid / i_out_ready  | o_out_row, o_out_column, o_out_char, o_out_last
//   cfg     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// Steps: a load beat that is not the last passes S_LD_WR in the back end; a pause
// or resume is done in S_IDLE. Every character write from the text RAM (final load
// beat, stop) passes S_RD and S_EM, and one from the scroll window (tick) passes
// S_WEM, after S_SCAN, S_STEP_RD and S_STEP_SH per scrolling slot; the single read
// port of the text RAM sets this.
// Reset is synchronous, active low; the text RAM and windows need no clearing.
// The two-beat queue keeps accepting, until it is full, while the back end waits on a stalled out beat.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_marquee_scroller_unit #(
    parameter int TEXT_DEPTH  = clms_pkg::TEXT_DEPTH_DEF,
    parameter int NUM_SLOTS   = clms_pkg::NUM_SLOTS_DEF,
    parameter int NUM_COLUMNS = clms_pkg::NUM_COLUMNS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [clms_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [clms_pkg::COL_W-1:0]      i_column,
    input  wire logic                            i_row,
    input  wire logic [clms_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic                            i_last,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_row,
    output logic [clms_pkg::COL_W-1:0]           o_out_column,
    output logic [clms_pkg::CHAR_W-1:0]          o_out_char,
    output logic                                 o_out_last,
    input  wire logic                            i_cfg_we,
    input  wire logic [clms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [clms_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clms_pkg::*;

    t_cfg  r_cfg;
    t_item q_item;
    logic  q_valid, q_ready;

    // settings: writes to an unknown index drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ticks   <= PERIOD_RST;
            r_cfg.delay_ticks    <= DELAY_RST;
            r_cfg.spacing_blanks <= SPACING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERIOD:  r_cfg.period_ticks   <= i_cfg_data;
                REG_DELAY:   r_cfg.delay_ticks    <= i_cfg_data;
                REG_SPACING: r_cfg.spacing_blanks <= i_cfg_data[SPACING_W-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    // front: accept and classify command beats
    clms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_item    (q_item)
    );

    // back: slot state, text RAM, character write sequencer
    clms_back #(
        .TEXT_DEPTH  (TEXT_DEPTH),
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_item     (q_item),
        .i_cfg        (r_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_row    (o_out_row),
        .o_out_column (o_out_column),
        .o_out_char   (o_out_char),
        .o_out_last   (o_out_last)
    );
endmodule
`default_nettype wire

// ----- rtl/core/clms_ram.sv -----
// clms_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module clms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/clms_front.sv -----
// clms_front: accepts command beats, classifies them and queues them (two entries).
// Depends on clms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clms_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [clms_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [clms_pkg::COL_W-1:0]  i_column,
    input  wire logic                        i_row,
    input  wire logic [clms_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                        i_last,
    output logic                             o_q_valid,
    input  wire logic                        i_q_ready,
    output clms_pkg::t_item                  o_q_item
);
    import clms_pkg::*;

    t_item      r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      dec;
    logic       push, pop;

    always_comb begin
        dec.column    = i_column;
        dec.row       = i_row;
        dec.char_code = i_char_code;
        dec.last      = i_last;
        dec.all_rows  = 1'b0;
        case (i_cmd)
            CMD_LOAD:       dec.kind = K_LOAD;
            CMD_PAUSE_ALL:  begin dec.kind = K_PAUSE;  dec.all_rows = 1'b1; end
            CMD_PAUSE_ROW:  dec.kind = K_PAUSE;
            CMD_RESUME_ALL: begin dec.kind = K_RESUME; dec.all_rows = 1'b1; end
            CMD_RESUME_ROW: dec.kind = K_RESUME;
            CMD_STOP_ALL:   begin dec.kind = K_STOP;   dec.all_rows = 1'b1; end
            CMD_STOP_ROW:   dec.kind = K_STOP;
            default:        dec.kind = K_TICK;
        endcase
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_ent[r_rp];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/clms_back.sv -----
// clms_back: executes queued commands, keeps slot state and the text RAM, emits writes.
// Depends on clms_pkg and clms_ram.
`timescale 1ns / 1ps
`default_nettype none
module clms_back #(
    parameter int TEXT_DEPTH  = clms_pkg::TEXT_DEPTH_DEF,
    parameter int NUM_SLOTS   = clms_pkg::NUM_SLOTS_DEF,
    parameter int NUM_COLUMNS = clms_pkg::NUM_COLUMNS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    output logic                             o_q_ready,
    input  wire clms_pkg::t_item             i_q_item,
    input  wire clms_pkg::t_cfg              i_cfg,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_out_row,
    output logic [clms_pkg::COL_W-1:0]       o_out_column,
    output logic [clms_pkg::CHAR_W-1:0]      o_out_char,
    output logic                             o_out_last
);
    import clms_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TEXT_DEPTH + 1);
    localparam int OFF_W  = $clog2(TEXT_DEPTH + 32);
    localparam int ADDR_W = $clog2(NUM_SLOTS * TEXT_DEPTH);
    localparam int IDX_W  = $clog2(NUM_COLUMNS);

    typedef enum logic [1:0] {M_OFF, M_PAUSE, M_RUN} t_mode;
    typedef enum logic [2:0] {
        S_IDLE, S_LD_WR, S_SCAN, S_RD, S_EM, S_STEP_RD, S_STEP_SH, S_WEM
    } t_state;
    typedef enum logic [1:0] {J_LOAD, J_STOP, J_TICK} t_job;

    t_state              r_state;
    t_job                r_job;
    t_mode               r_mode [NUM_SLOTS];
    logic [CNT_W-1:0]    r_len  [NUM_SLOTS];
    logic [OFF_W-1:0]    r_off  [NUM_SLOTS];
    logic [COL_W-1:0]    r_col  [NUM_SLOTS];
    logic                r_row  [NUM_SLOTS];
    logic [CHAR_W-1:0]   r_win  [NUM_SLOTS][NUM_COLUMNS];
    logic [7:0]          r_delay, r_period;
    logic [SLOT_W-1:0]   r_load_slot, r_s;
    logic [CNT_W-1:0]    r_load_cnt;
    logic [NUM_SLOTS-1:0] r_mask;
    logic [COL_W-1:0]    r_c;
    logic [CHAR_W-1:0]   r_char;
    logic                r_lastf, r_fill, r_space;

    logic [COL_W-1:0]    cur_col, idx_full;
    logic [IDX_W-1:0]    idx;
    logic [CNT_W-1:0]    room, cnt_nxt;
    logic [ADDR_W-1:0]   base, raddr, waddr;
    logic                re, we, out_free, col_end, more_above;
    logic [SLOT_W-1:0]   pick;
    logic [CHAR_W-1:0]   rdata, em_char, step_char;
    logic [OFF_W:0]      off_inc, wrap_lim;
    logic [8:0]          tick_cnt;
    logic                t_wake, t_expired;

    assign cur_col  = r_col[r_s];
    assign idx_full = r_c - cur_col;
    assign idx      = idx_full[IDX_W-1:0];
    assign room     = CNT_W'(NUM_COLUMNS) - CNT_W'(cur_col);
    assign base     = ADDR_W'(r_s) * ADDR_W'(TEXT_DEPTH);
    assign out_free = !o_out_valid || i_out_ready;
    assign col_end  = (r_c == COL_W'(NUM_COLUMNS - 1));
    assign cnt_nxt  = (r_load_cnt < CNT_W'(TEXT_DEPTH)) ? r_load_cnt + 1'b1 : r_load_cnt;
    assign em_char  = r_space ? SPACE_CHAR : rdata;
    assign step_char = (OFF_W'(r_len[r_s]) > r_off[r_s]) ? rdata : SPACE_CHAR;
    assign off_inc  = {1'b0, r_off[r_s]} + 1'b1;
    assign wrap_lim = (OFF_W+1)'(r_len[r_s]) + (OFF_W+1)'(i_cfg.spacing_blanks);
    assign tick_cnt = {1'b0, r_period} + 9'd1;
    assign t_wake   = tick_cnt >= {1'b0, i_cfg.period_ticks};
    assign t_expired = (r_delay == 8'd0);
    assign o_q_ready = (r_state == S_IDLE);

    always_comb begin
        pick = SLOT_W'(NUM_SLOTS - 1);
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_mode[k] == M_OFF) pick = SLOT_W'(k);
        end
        more_above = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (SLOT_W'(k) > r_s && r_mask[k]) more_above = 1'b1;
        end
    end

    always_comb begin
        re    = 1'b0;
        raddr = base + ADDR_W'(idx_full);
        we    = (r_state == S_LD_WR) && (r_load_cnt < CNT_W'(TEXT_DEPTH));
        waddr = base + ADDR_W'(r_load_cnt);
        case (r_state)
            S_RD:      re = 1'b1;
            S_STEP_RD: begin re = 1'b1; raddr = base + ADDR_W'(r_off[r_s]); end
            default:   re = 1'b0;
        endcase
    end

    clms_ram #(.WIDTH(CHAR_W), .DEPTH(NUM_SLOTS * TEXT_DEPTH)) u_text (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_char),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_LOAD;
            o_out_valid <= 1'b0;
            r_delay     <= 8'd0;
            r_period    <= 8'd0;
            r_load_slot <= '0;
            r_load_cnt  <= '0;
            r_s         <= '0;
            r_mask      <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_mode[k] <= M_OFF;
                r_len[k]  <= '0;
                r_off[k]  <= '0;
                r_col[k]  <= '0;
                r_row[k]  <= 1'b0;
            end
        end else begin
            if (i_out_ready) o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_item.kind)
                            K_LOAD: begin
                                r_char  <= i_q_item.char_code;
                                r_lastf <= i_q_item.last;
                                if (r_load_cnt == '0) begin
                                    r_mode[pick] <= M_OFF;
                                    r_load_slot  <= pick;
                                    r_s          <= pick;
                                    r_col[pick]  <= (i_q_item.column > COL_W'(NUM_COLUMNS - 1)) ?
                                                    COL_W'(NUM_COLUMNS - 1) : i_q_item.column;
                                    r_row[pick]  <= i_q_item.row;
                                end else begin
                                    r_s <= r_load_slot;
                                end
                                r_state <= S_LD_WR;
                            end
                            K_PAUSE: begin
                                for (int k = 0; k < NUM_SLOTS; k++) begin
                                    if (r_mode[k] == M_RUN &&
                                        (i_q_item.all_rows || r_row[k] == i_q_item.row))
                                        r_mode[k] <= M_PAUSE;
                                end
                            end
                            K_RESUME: begin
                                r_delay <= i_cfg.delay_ticks;
                                for (int k = 0; k < NUM_SLOTS; k++) begin
                                    if (r_mode[k] == M_PAUSE &&
                                        (i_q_item.all_rows || r_row[k] == i_q_item.row))
                                        r_mode[k] <= M_RUN;
                                end
                            end
                            K_STOP: begin
                                for (int k = 0; k < NUM_SLOTS; k++) begin
                                    r_mask[k] <= (r_mode[k] != M_OFF) &&
                                        (i_q_item.all_rows || r_row[k] == i_q_item.row);
                                end
                                r_job   <= J_STOP;
                                r_s     <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                if (!t_expired) r_delay <= r_delay - 8'd1;
                                r_period <= t_wake ? 8'd0 : tick_cnt[7:0];
                                if (t_wake && t_expired) begin
                                    for (int k = 0; k < NUM_SLOTS; k++) begin
                                        r_mask[k] <= (r_mode[k] == M_RUN);
                                    end
                                    r_job   <= J_TICK;
                                    r_s     <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                S_LD_WR: begin
                    r_load_cnt <= cnt_nxt;
                    r_state    <= S_IDLE;
                    if (r_lastf) begin
                        // whole string goes out now; scroll if it overflows the room
                        r_len[r_s] <= cnt_nxt;
                        r_fill     <= cnt_nxt > room;
                        if (cnt_nxt > room) begin
                            r_mode[r_s] <= M_RUN;
                            r_off[r_s]  <= OFF_W'(room);
                        end
                        r_delay    <= i_cfg.delay_ticks;
                        r_load_cnt <= '0;
                        r_mask     <= '0;
                        r_job      <= J_LOAD;
                        r_c        <= cur_col;
                        r_state    <= S_RD;
                    end
                end
                S_SCAN: begin
                    if (r_mask[r_s]) begin
                        r_c <= cur_col;
                        if (r_job == J_STOP) begin
                            r_mode[r_s] <= M_OFF;
                            r_space     <= 1'b0;
                            r_fill      <= 1'b0;
                            r_state     <= S_RD;
                        end else begin
                            r_state <= S_STEP_RD;
                        end
                    end else if (r_s == SLOT_W'(NUM_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_RD: begin
                    r_space <= !(CNT_W'(idx_full) < r_len[r_s]);
                    r_state <= S_EM;
                end
                S_STEP_RD: r_state <= S_STEP_SH;
                S_STEP_SH: begin
                    for (int i = 0; i < NUM_COLUMNS - 1; i++) begin
                        if (CNT_W'(i + 1) < room) r_win[r_s][i] <= r_win[r_s][i + 1];
                    end
                    for (int i = 0; i < NUM_COLUMNS; i++) begin
                        if (CNT_W'(i + 1) == room) r_win[r_s][i] <= step_char;
                    end
                    if (OFF_W'(r_len[r_s]) > r_off[r_s] || off_inc < wrap_lim)
                        r_off[r_s] <= off_inc[OFF_W-1:0];
                    else
                        r_off[r_s] <= '0;
                    r_state <= S_WEM;
                end
                S_EM, S_WEM: begin
                    if (out_free) begin
                        o_out_valid  <= 1'b1;
                        o_out_row    <= r_row[r_s];
                        o_out_column <= r_c;
                        o_out_char   <= (r_state == S_EM) ? em_char : r_win[r_s][idx];
                        o_out_last   <= col_end && !more_above;
                        if (r_state == S_EM && r_fill) r_win[r_s][idx] <= em_char;
                        if (!col_end) begin
                            r_c     <= r_c + 1'b1;
                            r_state <= (r_state == S_EM) ? S_RD : S_WEM;
                        end else if (r_job == J_LOAD || r_s == SLOT_W'(NUM_SLOTS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_s     <= r_s + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// testbench: self-checking bench for char_lcd_marquee_scroller_unit.
// Holds a behavioral model of the display writes and drives random command streams.
// Depends on clms_pkg and the RTL of the scroller.
`timescale 1ns / 1ps

// Behavioral model of the scroller plus the queue of display writes still owed.
class display_write_ledger;
    typedef struct {
        bit       row;
        bit [3:0] col;
        bit [7:0] ch;
        bit       last;
    } disp_write_t;

    localparam int NCOL  = clms_pkg::NUM_COLUMNS_DEF;
    localparam int NSLOT = clms_pkg::NUM_SLOTS_DEF;
    localparam int DEPTH = clms_pkg::TEXT_DEPTH_DEF;

    disp_write_t owed_q[$];
    int          errors;

    bit [7:0] period, delay;
    bit [4:0] blanks;
    bit [1:0] mode[NSLOT];
    bit [7:0] text[NSLOT][DEPTH];
    int       tlen[NSLOT];
    int       toff[NSLOT];
    bit [7:0] win[NSLOT][NCOL];
    int       scol[NSLOT];
    bit       srow[NSLOT];
    bit [7:0] delay_left, period_cnt;
    int       load_slot, load_cnt;

    localparam bit [1:0] M_OFF = 2'd0, M_PAUSE = 2'd1, M_RUN = 2'd2;

    function new();
        errors = 0;
        period = clms_pkg::PERIOD_RST;
        delay  = clms_pkg::DELAY_RST;
        blanks = clms_pkg::SPACING_RST;
        foreach (mode[s]) begin
            mode[s] = M_OFF; tlen[s] = 0; toff[s] = 0; scol[s] = 0; srow[s] = 0;
        end
        delay_left = 0; period_cnt = 0; load_slot = 0; load_cnt = 0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    function void add(ref disp_write_t b[$], input bit r, input int c, input bit [7:0] ch);
        disp_write_t w;
        w.row = r; w.col = c[3:0]; w.ch = ch; w.last = 0;
        b.push_back(w);
    endfunction

    // Advance the model by one accepted command beat.
    function void note_command(bit [2:0] cmd, bit [3:0] col, bit row, bit [7:0] ch, bit last);
        disp_write_t batch[$];
        int s, pick, room, len, i, cnt;
        bit expired, wake;
        case (cmd)
            clms_pkg::CMD_LOAD: begin
                if (load_cnt == 0) begin
                    pick = NSLOT - 1;
                    for (s = NSLOT - 1; s >= 0; s--)
                        if (mode[s] == M_OFF) pick = s;
                    mode[pick] = M_OFF;
                    load_slot = pick;
                    scol[pick] = (col > NCOL - 1) ? NCOL - 1 : col;
                    srow[pick] = row;
                end
                s = load_slot;
                if (load_cnt < DEPTH) begin
                    text[s][load_cnt] = ch;
                    load_cnt++;
                end
                if (last) begin
                    len = load_cnt;
                    room = NCOL - scol[s];
                    for (i = 0; i < room; i++)
                        add(batch, srow[s], scol[s] + i, (i < len) ? text[s][i] : clms_pkg::SPACE_CHAR);
                    tlen[s] = len;
                    if (len > room) begin
                        mode[s] = M_RUN;
                        toff[s] = room;
                        for (i = 0; i < room; i++) win[s][i] = text[s][i];
                    end
                    delay_left = delay;
                    load_cnt = 0;
                end
            end
            clms_pkg::CMD_PAUSE_ALL, clms_pkg::CMD_PAUSE_ROW: begin
                for (s = 0; s < NSLOT; s++)
                    if (mode[s] == M_RUN && (cmd == clms_pkg::CMD_PAUSE_ALL || srow[s] == row))
                        mode[s] = M_PAUSE;
            end
            clms_pkg::CMD_RESUME_ALL, clms_pkg::CMD_RESUME_ROW: begin
                delay_left = delay;
                for (s = 0; s < NSLOT; s++)
                    if (mode[s] == M_PAUSE && (cmd == clms_pkg::CMD_RESUME_ALL || srow[s] == row))
                        mode[s] = M_RUN;
            end
            clms_pkg::CMD_STOP_ALL, clms_pkg::CMD_STOP_ROW: begin
                for (s = 0; s < NSLOT; s++)
                    if (mode[s] != M_OFF && (cmd == clms_pkg::CMD_STOP_ALL || srow[s] == row)) begin
                        for (i = scol[s]; i < NCOL; i++)
                            add(batch, srow[s], i, text[s][i - scol[s]]);
                        mode[s] = M_OFF;
                    end
            end
            default: begin
                expired = (delay_left == 0);
                cnt = period_cnt + 1;
                wake = (cnt >= period);
                if (delay_left != 0) delay_left--;
                period_cnt = wake ? 8'd0 : cnt[7:0];
                if (wake && expired)
                    for (s = 0; s < NSLOT; s++)
                        if (mode[s] == M_RUN) begin
                            room = NCOL - scol[s];
                            for (i = 0; i + 1 < room; i++) win[s][i] = win[s][i + 1];
                            if (toff[s] < tlen[s]) begin
                                win[s][room - 1] = text[s][toff[s]];
                                toff[s]++;
                            end else begin
                                win[s][room - 1] = clms_pkg::SPACE_CHAR;
                                if (toff[s] + 1 < tlen[s] + blanks) toff[s]++;
                                else toff[s] = 0;
                            end
                            for (i = 0; i < room; i++)
                                add(batch, srow[s], scol[s] + i, win[s][i]);
                        end
            end
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1;
        foreach (batch[k]) owed_q.push_back(batch[k]);
    endfunction

    function void check_write(bit row, bit [3:0] col, bit [7:0] ch, bit last);
        disp_write_t w;
        if (owed_q.size() == 0) begin
            $error("unexpected write row=%0d col=%0d char=%0d", row, col, ch);
            errors++;
            return;
        end
        w = owed_q.pop_front();
        if (w.row != row) begin
            $error("out_row: expected %0d, got %0d", w.row, row); errors++;
        end
        if (w.col != col) begin
            $error("out_column: expected %0d, got %0d", w.col, col); errors++;
        end
        if (w.ch != ch) begin
            $error("out_char: expected %0d, got %0d", w.ch, ch); errors++;
        end
        if (w.last != last) begin
            $error("out_last: expected %0d, got %0d", w.last, last); errors++;
        end
    endfunction
endclass

module testbench;
    import clms_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 40;   // covers the longest write-free command in the core
    localparam int LONG_LEN    = 258;  // one string longer than the text store

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd = CMD_TICK;
    logic [COL_W-1:0]      column = 0;
    logic                  row = 0;
    logic [CHAR_W-1:0]     char_code = 0;
    logic                  last = 0;
    logic                  out_valid;
    logic                  out_ready = 0;
    logic                  out_row;
    logic [COL_W-1:0]      out_column;
    logic [CHAR_W-1:0]     out_char;
    logic                  out_last;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_idx = REG_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data = 0;

    bit  gaps_on = 1;     // clear for a stretch with no idling on either side
    int  idle_cycles = 0;

    display_write_ledger sb = new();

    always #1 i_clk = ~i_clk;

    char_lcd_marquee_scroller_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_column(column), .i_row(row), .i_char_code(char_code), .i_last(last),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_row(out_row), .o_out_column(out_column), .o_out_char(out_char),
        .o_out_last(out_last),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // Monitor both channels: feed accepted commands to the model, check every write beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready)
                sb.note_command(cmd, column, row, char_code, last);
            if (out_valid && out_ready)
                sb.check_write(out_row, out_column, out_char, out_last);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: stop a run that makes no progress.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Display side: stall about a third of the time unless gaps are off.
    always @(posedge i_clk)
        out_ready <= !(gaps_on && $urandom_range(99) < 33);

    // Offer one command beat and hold it until it is taken.
    task automatic send_beat(input logic [CMD_W-1:0] c, input logic [COL_W-1:0] col,
                             input logic r, input logic [CHAR_W-1:0] ch, input logic l);
        while (gaps_on && $urandom_range(99) < 33) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid  <= 1;
        cmd       <= c;
        column    <= col;
        row       <= r;
        char_code <= ch;
        last      <= l;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Hold off the sender until every owed write has come out, then let the core settle.
    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] per, input logic [7:0] dly, input logic [4:0] sp);
        cfg_we <= 1; cfg_idx <= REG_PERIOD; cfg_data <= per;
        @(posedge i_clk);
        cfg_idx <= REG_DELAY; cfg_data <= dly;
        @(posedge i_clk);
        cfg_idx <= REG_SPACING; cfg_data <= {3'b0, sp};
        @(posedge i_clk);
        cfg_we <= 0;
        sb.period = per; sb.delay = dly; sb.blanks = sp;
        @(posedge i_clk);
    endtask

    // Random traffic: mostly complete strings and ticks, some control and some noise.
    task automatic random_phase(input int n_items);
        int k, left, r;
        logic [COL_W-1:0] col;
        logic rw;
        left = 0;
        col = 0;
        rw = 0;
        for (k = 0; k < n_items; k++) begin
            if (left > 0) begin
                send_beat(CMD_LOAD, COL_W'($urandom), 1'($urandom), CHAR_W'($urandom),
                          left == 1);
                left--;
            end else begin
                r = $urandom_range(99);
                if (r < 2) begin
                    drain();
                end else if (r < 24) begin
                    col = COL_W'($urandom_range(15));
                    rw = 1'($urandom);
                    if ($urandom_range(3) == 0) begin
                        left = $urandom_range(1, 6);
                    end else begin
                        left = $urandom_range(7, 24);
                    end
                    send_beat(CMD_LOAD, col, rw, CHAR_W'($urandom), left == 1);
                    left--;
                end else if (r < 72) begin
                    send_beat(CMD_TICK, COL_W'($urandom), 1'($urandom), CHAR_W'($urandom),
                              1'($urandom));
                end else if (r < 76) begin
                    send_beat(CMD_W'($urandom), COL_W'($urandom), 1'($urandom),
                              CHAR_W'($urandom), 1'($urandom));
                end else begin
                    send_beat(CMD_W'($urandom_range(CMD_PAUSE_ALL, CMD_STOP_ROW)),
                              COL_W'($urandom), 1'($urandom), CHAR_W'($urandom),
                              1'($urandom));
                end
            end
        end
        // finish any open string so the phase ends with the core in a known state
        while (left > 0) begin
            send_beat(CMD_LOAD, COL_W'($urandom), 1'($urandom), CHAR_W'($urandom), left == 1);
            left--;
        end
    endtask

    initial begin
        int i;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: short string with code 0, clamped column, scrolling string, controls.
        send_beat(CMD_LOAD, 4'd0, 1'b0, 8'h00, 1'b1);
        send_beat(CMD_LOAD, 4'd15, 1'b1, 8'hFF, 1'b0);
        send_beat(CMD_LOAD, 4'd15, 1'b1, 8'h78, 1'b1);
        for (i = 0; i < 14; i++)
            send_beat(CMD_LOAD, 4'd3, 1'b0, (i == 0) ? 8'hFF : CHAR_W'(8'h41 + i), i == 13);
        send_beat(CMD_PAUSE_ROW, 4'd0, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_PAUSE_ALL, 4'd0, 1'b1, 8'h00, 1'b0);
        send_beat(CMD_RESUME_ROW, 4'd0, 1'b1, 8'h00, 1'b0);
        send_beat(CMD_RESUME_ALL, 4'd0, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_TICK, 4'd0, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_STOP_ROW, 4'd0, 1'b1, 8'h00, 1'b0);
        send_beat(CMD_STOP_ALL, 4'd0, 1'b0, 8'h00, 1'b0);
        send_beat(CMD_TICK, 4'd0, 1'b0, 8'h00, 1'b0);
        drain();

        // Fastest settings.
        set_regs(8'd1, 8'd0, 5'd1);
        random_phase(20);
        drain();

        // A stretch with no gaps at all: overflow the text store, then scroll it.
        gaps_on = 0;
        set_regs(8'd2, 8'd1, 5'd31);
        for (i = 0; i < LONG_LEN; i++)
            send_beat(CMD_LOAD, 4'd2, 1'b1, CHAR_W'($urandom), i == LONG_LEN - 1);
        random_phase(8);
        drain();
        gaps_on = 1;

        set_regs(8'd255, 8'd255, 5'd31);
        random_phase(4);
        drain();
        set_regs(8'd3, 8'd2, 5'd5);
        random_phase(10);
        drain();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
